[rtl/core/clrf_pkg.sv]
// Shared types and constants of the character LCD refresh block.
`timescale 1ns / 1ps
package clrf_pkg;

	// Default display geometry.
	localparam int DEF_COLUMNS = 16;
	localparam int DEF_ROWS    = 2;

	// Widest cell index over the supported geometries (40 x 2 cells).
	localparam int CELL_AW = 7;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Display controller constants.
	localparam logic [7:0] SPACE_CODE    = 8'h20;
	localparam logic [7:0] SET_ADDR_BASE = 8'h80;
	localparam logic [7:0] ROW_STRIDE    = 8'h40;

	// Input item kinds.
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_CURSOR  = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;
	localparam logic [1:0] KIND_REFRESH = 2'd3;

	// Operations carried out by the back end.
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_REFRESH = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [7:0]         code;
		logic [CELL_AW-1:0] cell_idx;
	} cmd_t;

	// A command together with its valid flag.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

[rtl/core/clrf_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module clrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/clrf_front.sv]
// Front end: accepts input items, keeps the cursor and issues store commands.
`timescale 1ns / 1ps
module clrf_front #(
	parameter int COLUMNS = clrf_pkg::DEF_COLUMNS,
	parameter int ROWS    = clrf_pkg::DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              q_full,
	output clrf_pkg::cmd_req_t push
);

	import clrf_pkg::*;

	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	// Remainder of a value below 64 by a small divisor, by restoring subtraction.
	function automatic int mod_small(int v, int d);
		int r;
		r = v;
		for (int k = 5; k >= 0; k--) begin
			if (r >= (d << k)) begin
				r = r - (d << k);
			end
		end
		return r;
	endfunction

	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic          acc;
	logic [1:0]    kind;
	logic [7:0]    code;
	logic [5:0]    new_col;
	logic [1:0]    new_row;
	logic          col_wrap;
	logic          row_wrap;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;
	assign kind     = s_tuser;
	assign code     = s_tdata[7:0];
	assign new_col  = s_tdata[13:8];
	assign new_row  = s_tdata[15:14];
	assign col_wrap = (int'(cur_col_q) == COLUMNS - 1);
	assign row_wrap = (int'(cur_row_q) == ROWS - 1);

	always_comb begin
		push.valid        = acc && (kind != KIND_CURSOR);
		push.cmd.code     = code;
		push.cmd.cell_idx = CELL_AW'(int'(cur_row_q) * COLUMNS + int'(cur_col_q));
		case (kind)
			KIND_WRITE:   push.cmd.op = OP_WRITE;
			KIND_CLEAR:   push.cmd.op = OP_CLEAR;
			KIND_REFRESH: push.cmd.op = OP_REFRESH;
			default:      push.cmd.op = OP_WRITE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (acc) begin
			case (kind)
				KIND_WRITE: begin
					if (col_wrap) begin
						cur_col_q <= '0;
						cur_row_q <= row_wrap ? '0 : RW'(int'(cur_row_q) + 1);
					end else begin
						cur_col_q <= CW'(int'(cur_col_q) + 1);
					end
				end
				KIND_CURSOR: begin
					cur_col_q <= CW'(mod_small(int'(new_col), COLUMNS));
					cur_row_q <= RW'(mod_small(int'(new_row), ROWS));
				end
				KIND_CLEAR: begin
					cur_col_q <= '0;
					cur_row_q <= '0;
				end
				default: begin
					cur_col_q <= cur_col_q;
				end
			endcase
		end
	end

endmodule

[rtl/core/clrf_queue.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module clrf_queue #(
	parameter int DEPTH = clrf_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clrf_pkg::cmd_req_t push,
	output logic               full,
	output clrf_pkg::cmd_req_t head,
	input  logic               pop
);

	import clrf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          ent_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (int'(count_q) == DEPTH);
	assign head.valid = (count_q != '0);
	assign head.cmd   = ent_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : PW'(int'(wr_ptr_q) + 1);
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : PW'(int'(rd_ptr_q) + 1);
			end
			if (do_push && !do_pop) begin
				count_q <= NW'(int'(count_q) + 1);
			end else if (do_pop && !do_push) begin
				count_q <= NW'(int'(count_q) - 1);
			end
		end
	end

endmodule

[rtl/core/clrf_back.sv]
// Back end: screen and shadow stores, refresh scan and output register.
`timescale 1ns / 1ps
module clrf_back #(
	parameter int COLUMNS = clrf_pkg::DEF_COLUMNS,
	parameter int ROWS    = clrf_pkg::DEF_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clrf_pkg::cmd_req_t head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);

	import clrf_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int IW    = $clog2(CELLS + 1);
	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t        state_q;
	logic [IW-1:0] rd_idx_q;
	logic [CW-1:0] rd_col_q;
	logic [RW-1:0] rd_row_q;
	logic          s1_v_s1;
	logic [AW-1:0] s1_idx_s1;
	logic [CW-1:0] s1_col_s1;
	logic [RW-1:0] s1_row_s1;
	logic          held_v_q;
	logic [7:0]    held_data_q;
	logic [CELLS-1:0] scr_vld_q;
	logic [CELLS-1:0] shd_vld_q;
	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;
	logic          m_tuser_q;
	logic          m_tlast_q;

	logic          out_ok;
	logic          scanning;
	logic          issuing;
	logic [7:0]    scr_rdata;
	logic [7:0]    shd_rdata;
	logic [7:0]    scr_cell;
	logic [7:0]    shd_cell;
	logic          dirty;
	logic          emit_held;
	logic          emit_addr;
	logic          emit_final;
	logic          stall;
	logic [AW-1:0] raddr;
	logic          scr_we;
	logic [7:0]    addr_byte;

	assign out_ok   = !m_tvalid_q || m_tready;
	assign scanning = (state_q == ST_SCAN);
	assign issuing  = (int'(rd_idx_q) != CELLS);
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign scr_we   = pop && (head.cmd.op == OP_WRITE);

	// Screen cells never written since reset or clear read as spaces; shadow cells never written since reset read as zero.
	assign scr_cell = scr_vld_q[s1_idx_s1] ? scr_rdata : SPACE_CODE;
	assign shd_cell = shd_vld_q[s1_idx_s1] ? shd_rdata : 8'h00;

	assign dirty      = scanning && s1_v_s1 && (scr_cell != shd_cell);
	assign emit_held  = dirty && held_v_q && out_ok;
	assign emit_addr  = dirty && !held_v_q && out_ok;
	assign stall      = dirty && !emit_addr;
	assign emit_final = (state_q == ST_DONE) && held_v_q && out_ok;

	// While stalled, the cell under compare is read again so its data holds.
	assign raddr = stall ? s1_idx_s1 : (issuing ? rd_idx_q[AW-1:0] : '0);

	assign addr_byte = 8'(int'(SET_ADDR_BASE) + int'(s1_row_s1) * int'(ROW_STRIDE)
		+ int'(s1_col_s1));

	clrf_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (scr_we),
		.waddr(head.cmd.cell_idx[AW-1:0]),
		.wdata(head.cmd.code),
		.raddr(raddr),
		.rdata(scr_rdata)
	);

	clrf_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_shadow (
		.clk  (clk),
		.we   (emit_addr),
		.waddr(s1_idx_s1),
		.wdata(scr_cell),
		.raddr(raddr),
		.rdata(shd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			rd_col_q  <= '0;
			rd_row_q  <= '0;
			s1_v_s1   <= 1'b0;
			held_v_q  <= 1'b0;
			scr_vld_q <= '0;
			shd_vld_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						case (head.cmd.op)
							OP_WRITE:   scr_vld_q[head.cmd.cell_idx[AW-1:0]] <= 1'b1;
							OP_CLEAR:   scr_vld_q <= '0;
							OP_REFRESH: begin
								state_q  <= ST_SCAN;
								rd_idx_q <= '0;
								rd_col_q <= '0;
								rd_row_q <= '0;
								s1_v_s1  <= 1'b0;
							end
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					if (emit_addr) begin
						shd_vld_q[s1_idx_s1] <= 1'b1;
						held_v_q             <= 1'b1;
					end else if (emit_held) begin
						held_v_q <= 1'b0;
					end
					if (!stall) begin
						s1_v_s1 <= issuing;
						if (issuing) begin
							rd_idx_q <= IW'(int'(rd_idx_q) + 1);
							if (int'(rd_col_q) == COLUMNS - 1) begin
								rd_col_q <= '0;
								rd_row_q <= (int'(rd_row_q) == ROWS - 1) ? '0
									: RW'(int'(rd_row_q) + 1);
							end else begin
								rd_col_q <= CW'(int'(rd_col_q) + 1);
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!held_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_ok) begin
						held_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload of the scan stage and of the held data byte.
	always_ff @(posedge clk) begin
		if (scanning && !stall) begin
			s1_idx_s1 <= rd_idx_q[AW-1:0];
			s1_col_s1 <= rd_col_q;
			s1_row_s1 <= rd_row_q;
		end
		if (emit_addr) begin
			held_data_q <= scr_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_addr || emit_held || emit_final) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_addr) begin
			m_tdata_q <= addr_byte;
			m_tuser_q <= 1'b0;
			m_tlast_q <= 1'b0;
		end else if (emit_held || emit_final) begin
			m_tdata_q <= held_data_q;
			m_tuser_q <= 1'b1;
			m_tlast_q <= emit_final;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

[rtl/core/char_lcd_dirty_refresh_top.sv]
// Top level of the character LCD frame store with dirty-cell refresh.
`timescale 1ns / 1ps
// The block holds a screen store of ROWS x COLUMNS characters, a shadow copy of
// what the display was last sent, and a write cursor. Items arrive on the slave
// stream: tuser carries the kind (write char, set cursor, clear, refresh) and
// tdata the character byte, cursor column and cursor row. A transfer is taken
// whenever the four-entry command queue between the front and back ends has
// room, so the front end takes one item per cycle until the queue fills.
// Write-char and clear items are carried out as soon as the idle back end pops
// them. A refresh walks every cell once, one cell per cycle through the store
// read port while the scan does not stall; each dirty cell after the first
// stalls the scan, since its set-address command and data byte go out through
// a single output register. Results leave on the master stream: tdata is the
// byte, tuser is high for a data byte and low for a command, and tlast marks
// the final byte of a refresh run. A refresh with no dirty cell sends nothing.
// The last data byte of a run is held back until the scan ends; a dirty cell's
// set-address command passes the store read register, then the output register.
// When the receiver stalls the scan waits on the pending cell and the queue
// fills behind it; nothing is dropped. After reset the screen reads as all
// spaces, the shadow as all zeros and the cursor sits at column 0, row 0;
// no clearing pass is needed, so the first item can follow reset directly.
module char_lcd_dirty_refresh_top #(
	parameter int COLUMNS = clrf_pkg::DEF_COLUMNS,
	parameter int ROWS    = clrf_pkg::DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: char_code[7:0], cursor_col[13:8], cursor_row[15:14].
	input  logic [15:0] s_tdata,
	// Fields from bit 0: kind[1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: out_byte[7:0].
	output logic [7:0]  m_tdata,
	// Fields from bit 0: is_data[0].
	output logic        m_tuser,
	output logic        m_tlast
);

	import clrf_pkg::*;

	cmd_req_t push;
	cmd_req_t head;
	logic     q_full;
	logic     pop;

	// Front end: cursor tracking and translation of items into store commands.
	clrf_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_full  (q_full),
		.push    (push)
	);

	// The queue lets the front end keep taking items during a long refresh.
	clrf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	// Back end: the stores, the refresh scan and the output register.
	clrf_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
